// ----- hw/rtl/pazs_pkg.sv -----
`default_nettype none

package pazs_pkg;

    // Default sample width of the sensor converter.
    localparam int SAMPLE_BITS_DEF = 10;

    // Fixed field widths.
    localparam int LEN_BITS        = 8;
    localparam int LEVEL_BITS      = 10;
    localparam int OUT_LEVEL_BITS  = 12;
    localparam int SPEED_BITS      = 8;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 10;

    // The speed dividend is 255 times a level below the far level.
    localparam int SPEED_DIV_BITS  = LEVEL_BITS + SPEED_BITS;

    localparam int QUEUE_DEPTH     = 2;

    localparam logic [SPEED_BITS-1:0] SPEED_FULL = 8'd255;
    localparam logic [SPEED_BITS-1:0] SPEED_ZERO = 8'd0;

    // Register reset values.
    localparam logic [LEN_BITS-1:0]   RST_BLOCK_LENGTH    = 8'd10;
    localparam logic [LEVEL_BITS-1:0] RST_FAR_LEVEL       = 10'd600;
    localparam logic [LEVEL_BITS-1:0] RST_NEAR_LEVEL      = 10'd310;
    localparam logic [LEVEL_BITS-1:0] RST_CLOSE_LEVEL     = 10'd130;
    localparam logic [LEVEL_BITS-1:0] RST_TOO_CLOSE_LEVEL = 10'd40;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BLOCK_LENGTH    = 3'd0,
        REG_FAR_LEVEL       = 3'd1,
        REG_NEAR_LEVEL      = 3'd2,
        REG_CLOSE_LEVEL     = 3'd3,
        REG_TOO_CLOSE_LEVEL = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [LEN_BITS-1:0]   block_length;
        logic [LEVEL_BITS-1:0] far_level;
        logic [LEVEL_BITS-1:0] near_level;
        logic [LEVEL_BITS-1:0] close_level;
        logic [LEVEL_BITS-1:0] too_close_level;
    } t_cfg;

    typedef enum logic [1:0] {
        ZONE_TOO_CLOSE = 2'd0,
        ZONE_CLOSE     = 2'd1,
        ZONE_NEAR      = 2'd2,
        ZONE_FAR       = 2'd3
    } t_zone;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_SPEED,
        ST_SDIV,
        ST_OUT
    } t_back_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Width of the block sum for a given sample width.
    function automatic int sum_bits(input int sb);
        return sb + LEN_BITS;
    endfunction

    // Width of the shared divider: wide enough for the block sum and
    // for the speed dividend.
    function automatic int div_bits(input int sb);
        return (sb + LEN_BITS > SPEED_DIV_BITS) ? sb + LEN_BITS : SPEED_DIV_BITS;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pazs_sample_if.sv -----
`default_nettype none

interface pazs_sample_if #(
    parameter int SAMPLE_BITS = pazs_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pazs_result_if.sv -----
`default_nettype none

interface pazs_result_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       block_done;
    logic signed [pazs_pkg::OUT_LEVEL_BITS-1:0] remapped_level;
    logic [1:0]                                 zone;
    logic [pazs_pkg::SPEED_BITS-1:0]            speed;

    modport source (output valid, output block_done, output remapped_level,
                    output zone, output speed, input ready);
    modport sink   (input valid, input block_done, input remapped_level,
                    input zone, input speed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pazs_cfg_if.sv -----
`default_nettype none

interface pazs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pazs_pkg::CFG_IDX_BITS-1:0]   index;
    logic [pazs_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pazs_front.sv -----
`default_nettype none

module pazs_front #(
    parameter int  SAMPLE_BITS = pazs_pkg::SAMPLE_BITS_DEF,
    localparam int SUM_BITS    = pazs_pkg::sum_bits(SAMPLE_BITS),
    localparam int ENTRY_BITS  = 1 + SUM_BITS + pazs_pkg::LEN_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    pazs_sample_if.sink            i_sample,
    input  wire pazs_pkg::t_cfg    i_cfg,
    input  wire pazs_pkg::t_q_stat i_q_stat,
    output logic                   o_push,
    output logic [ENTRY_BITS-1:0]  o_push_data
);

    localparam int LB = pazs_pkg::LEN_BITS;

    logic [LB-1:0]       r_count, n_count;
    logic [SUM_BITS-1:0] r_sum, n_sum;

    logic [LB-1:0]       len_eff;
    logic [LB:0]         cnt_inc;
    logic [SUM_BITS-1:0] sum_inc;
    logic                close;
    logic                accept;

    assign i_sample.ready = !i_q_stat.full;

    always_comb begin
        len_eff = (i_cfg.block_length == '0) ? LB'(1) : i_cfg.block_length;
        cnt_inc = {1'b0, r_count} + (LB+1)'(1);
        sum_inc = r_sum + SUM_BITS'(i_sample.sample);
        // A block closes on the count wrapping or reaching the length.
        close   = cnt_inc[LB] | (cnt_inc[LB-1:0] >= len_eff);
        accept  = i_sample.valid & i_sample.ready;

        n_count = r_count;
        n_sum   = r_sum;
        if (accept) begin
            if (close) begin
                n_count = '0;
                n_sum   = '0;
            end else begin
                n_count = cnt_inc[LB-1:0];
                n_sum   = sum_inc;
            end
        end

        o_push      = accept;
        o_push_data = {close, sum_inc, len_eff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pazs_queue.sv -----
`default_nettype none

module pazs_queue #(
    parameter int  WIDTH    = 1,
    parameter int  DEPTH    = pazs_pkg::QUEUE_DEPTH,
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [WIDTH-1:0]  i_push_data,
    input  wire logic              i_pop,
    output logic [WIDTH-1:0]       o_pop_data,
    output pazs_pkg::t_q_stat      o_stat
);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;

    function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_next(r_rd_ptr) : r_rd_ptr;
        n_cnt    = r_cnt + CNT_BITS'(i_push) - CNT_BITS'(i_pop);

        o_stat.full  = (r_cnt == CNT_BITS'(DEPTH));
        o_stat.empty = (r_cnt == '0);
        o_pop_data   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != CNT_BITS'(DEPTH)))
        else $error("queue pushed while full");

endmodule

`default_nettype wire

// ----- hw/rtl/pazs_div.sv -----
`default_nettype none

module pazs_div #(
    parameter int  DIV_BITS = pazs_pkg::div_bits(pazs_pkg::SAMPLE_BITS_DEF),
    localparam int DVS_BITS = pazs_pkg::LEVEL_BITS,
    localparam int CNT_BITS = $clog2(DIV_BITS + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_BITS-1:0]  i_dividend,
    input  wire logic [DVS_BITS-1:0]  i_divisor,
    output logic [DIV_BITS-1:0]       o_quotient,
    output pazs_pkg::t_div_stat       o_stat
);

    logic [DIV_BITS-1:0] r_quo, n_quo;
    logic [DVS_BITS-1:0] r_rem, n_rem;
    logic [DVS_BITS-1:0] r_dvs;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;

    logic [DVS_BITS:0]   rem_sh;
    logic [DVS_BITS:0]   rem_sub;
    logic                ge;

    // Restoring division, one quotient bit per cycle. The partial
    // remainder stays below the divisor, so it fits the divisor width.
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_BITS-1]};
        ge      = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};

        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = CNT_BITS'(DIV_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[DIV_BITS-2:0], ge};
            n_rem = ge ? rem_sub[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
            n_cnt = r_cnt - CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end

        o_quotient  = r_quo;
        o_stat.busy = r_busy;
        o_stat.done = r_done;
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    a_done_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_done)
        else $error("divider left busy without signalling done");

endmodule

`default_nettype wire

// ----- hw/rtl/pazs_back.sv -----
`default_nettype none

module pazs_back #(
    parameter int  SAMPLE_BITS = pazs_pkg::SAMPLE_BITS_DEF,
    localparam int SUM_BITS    = pazs_pkg::sum_bits(SAMPLE_BITS),
    localparam int ENTRY_BITS  = 1 + SUM_BITS + pazs_pkg::LEN_BITS,
    localparam int DIV_BITS    = pazs_pkg::div_bits(SAMPLE_BITS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pazs_pkg::t_cfg                i_cfg,
    input  wire pazs_pkg::t_q_stat             i_q_stat,
    output logic                               o_pop,
    input  wire logic [ENTRY_BITS-1:0]         i_pop_data,
    output logic                               o_div_start,
    output logic [DIV_BITS-1:0]                o_div_dividend,
    output logic [pazs_pkg::LEVEL_BITS-1:0]    o_div_divisor,
    input  wire logic [DIV_BITS-1:0]           i_div_quotient,
    input  wire pazs_pkg::t_div_stat           i_div_stat,
    pazs_result_if.source                      o_result
);

    localparam int LB = pazs_pkg::LEN_BITS;
    localparam int VB = pazs_pkg::LEVEL_BITS;
    localparam int SB = pazs_pkg::SPEED_BITS;
    localparam int OB = pazs_pkg::OUT_LEVEL_BITS;
    localparam int PB = pazs_pkg::SPEED_DIV_BITS;
    // Signed remap: far plus too-close minus a mean of up to SUM_BITS bits.
    localparam int RW = SUM_BITS + 1;

    pazs_pkg::t_back_state r_state, n_state;
    logic [RW-1:0]         r_remap, n_remap;
    logic [SB-1:0]         r_speed, n_speed;
    logic                  r_done_flag, n_done_flag;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_done;
    logic [OB-1:0]         r_out_level;
    pazs_pkg::t_zone       r_out_zone;
    logic [SB-1:0]         r_out_speed;

    logic                  head_close;
    logic [SUM_BITS-1:0]   head_sum;
    logic [LB-1:0]         head_len;
    logic [RW-1:0]         far_ext;
    logic [RW-1:0]         mean_remap;
    logic [PB-1:0]         prod;
    logic                  remap_pos;
    logic                  remap_sat;
    logic                  load;
    pazs_pkg::t_zone       zone;

    always_comb begin
        head_close = i_pop_data[ENTRY_BITS-1];
        head_sum   = i_pop_data[LB +: SUM_BITS];
        head_len   = i_pop_data[LB-1:0];

        far_ext    = RW'(i_cfg.far_level);
        mean_remap = far_ext + RW'(i_cfg.too_close_level)
                     - RW'(i_div_quotient[SUM_BITS-1:0]);
        remap_pos  = !r_remap[RW-1] && (r_remap != '0);
        remap_sat  = remap_pos && (r_remap >= far_ext);
        // 255 times the remap, valid when 0 < remap < far.
        prod       = {r_remap[VB-1:0], SB'(0)} - PB'(r_remap[VB-1:0]);

        if ($signed(r_remap) <= $signed(RW'(i_cfg.too_close_level))) begin
            zone = pazs_pkg::ZONE_TOO_CLOSE;
        end else if ($signed(r_remap) <= $signed(RW'(i_cfg.close_level))) begin
            zone = pazs_pkg::ZONE_CLOSE;
        end else if ($signed(r_remap) <= $signed(RW'(i_cfg.near_level))) begin
            zone = pazs_pkg::ZONE_NEAR;
        end else begin
            zone = pazs_pkg::ZONE_FAR;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_remap        = r_remap;
        n_speed        = r_speed;
        n_done_flag    = r_done_flag;
        o_pop          = 1'b0;
        o_div_start    = 1'b0;
        o_div_dividend = DIV_BITS'(head_sum);
        o_div_divisor  = VB'(head_len);
        load           = 1'b0;

        case (r_state)
            pazs_pkg::ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop       = 1'b1;
                    n_done_flag = head_close;
                    if (head_close) begin
                        o_div_start = 1'b1;
                        n_state     = pazs_pkg::ST_MEAN;
                    end else begin
                        n_state = pazs_pkg::ST_SPEED;
                    end
                end
            end
            pazs_pkg::ST_MEAN: begin
                if (i_div_stat.done) begin
                    n_remap = mean_remap;
                    n_state = pazs_pkg::ST_SPEED;
                end
            end
            pazs_pkg::ST_SPEED: begin
                if (!remap_pos) begin
                    n_speed = pazs_pkg::SPEED_ZERO;
                    n_state = pazs_pkg::ST_OUT;
                end else if (remap_sat) begin
                    n_speed = pazs_pkg::SPEED_FULL;
                    n_state = pazs_pkg::ST_OUT;
                end else begin
                    o_div_start    = 1'b1;
                    o_div_dividend = DIV_BITS'(prod);
                    o_div_divisor  = i_cfg.far_level;
                    n_state        = pazs_pkg::ST_SDIV;
                end
            end
            pazs_pkg::ST_SDIV: begin
                if (i_div_stat.done) begin
                    n_speed = i_div_quotient[SB-1:0];
                    n_state = pazs_pkg::ST_OUT;
                end
            end
            pazs_pkg::ST_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    load    = 1'b1;
                    n_state = pazs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pazs_pkg::ST_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && !o_result.ready) || load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pazs_pkg::ST_IDLE;
            r_remap     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remap     <= n_remap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_speed     <= n_speed;
        r_done_flag <= n_done_flag;
        if (load) begin
            r_out_done  <= r_done_flag;
            r_out_level <= r_remap[OB-1:0];
            r_out_zone  <= zone;
            r_out_speed <= r_speed;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.block_done     = r_out_done;
    assign o_result.remapped_level = r_out_level;
    assign o_result.zone           = r_out_zone;
    assign o_result.speed          = r_out_speed;

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_start |-> !i_div_stat.busy)
        else $error("divider started while busy");

    a_sdiv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pazs_pkg::ST_SDIV) |-> (!r_remap[RW-1] && (r_remap < far_ext)))
        else $error("speed division on a remap outside the open range");

endmodule

`default_nettype wire

// ----- hw/rtl/proximity_average_zone_speed_core.sv -----
// Path: a sample enters the queue, then the back end steps through ST_IDLE, ST_MEAN when
// the entry closes a block, ST_SPEED, ST_SDIV when the speed needs a division, and ST_OUT
// into the output register. The shared bit-serial divider is max(SAMPLE_BITS+8, 18) bits wide.
// The back end handles one queue entry at a time; the divider produces one bit per cycle.
// Reset (i_rst_n low at a clock edge) clears the block count, sum, held remap, the queue
// and the output valid flag, and returns all configuration registers to their defaults.
`default_nettype none

module proximity_average_zone_speed_core #(
    parameter int SAMPLE_BITS = pazs_pkg::SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH = pazs_pkg::QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    pazs_sample_if.sink    i_sample,
    pazs_cfg_if.sink       i_cfg,
    pazs_result_if.source  o_result
);

    localparam int SUM_BITS   = pazs_pkg::sum_bits(SAMPLE_BITS);
    localparam int ENTRY_BITS = 1 + SUM_BITS + pazs_pkg::LEN_BITS;
    localparam int DIV_BITS   = pazs_pkg::div_bits(SAMPLE_BITS);

    // The configuration register file. Writes are always taken; an index
    // beyond the register list completes its transaction and changes nothing.
    // Writes must arrive only while the block is idle; the block itself does
    // not enforce this. The front and back read these registers directly.
    pazs_pkg::t_cfg r_cfg, n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (pazs_pkg::t_reg_idx'(i_cfg.index))
                pazs_pkg::REG_BLOCK_LENGTH:
                    n_cfg.block_length = i_cfg.data[pazs_pkg::LEN_BITS-1:0];
                pazs_pkg::REG_FAR_LEVEL:
                    n_cfg.far_level = i_cfg.data[pazs_pkg::LEVEL_BITS-1:0];
                pazs_pkg::REG_NEAR_LEVEL:
                    n_cfg.near_level = i_cfg.data[pazs_pkg::LEVEL_BITS-1:0];
                pazs_pkg::REG_CLOSE_LEVEL:
                    n_cfg.close_level = i_cfg.data[pazs_pkg::LEVEL_BITS-1:0];
                pazs_pkg::REG_TOO_CLOSE_LEVEL:
                    n_cfg.too_close_level = i_cfg.data[pazs_pkg::LEVEL_BITS-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_length    <= pazs_pkg::RST_BLOCK_LENGTH;
            r_cfg.far_level       <= pazs_pkg::RST_FAR_LEVEL;
            r_cfg.near_level      <= pazs_pkg::RST_NEAR_LEVEL;
            r_cfg.close_level     <= pazs_pkg::RST_CLOSE_LEVEL;
            r_cfg.too_close_level <= pazs_pkg::RST_TOO_CLOSE_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The front end accepts each sample, adds it to the block sum and decides
    // whether it closes a block. It pushes one entry per sample into the queue:
    // the close flag, the sum including that sample and the effective block length.
    logic                  push;
    logic [ENTRY_BITS-1:0] push_data;
    logic                  pop;
    logic [ENTRY_BITS-1:0] pop_data;
    pazs_pkg::t_q_stat     q_stat;

    pazs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .i_cfg       (r_cfg),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // The queue lets the front keep taking samples while the back end divides
    // or while a result waits in the output register.
    pazs_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    // One restoring divider serves both the block mean and the speed scaling.
    logic                               div_start;
    logic [DIV_BITS-1:0]                div_dividend;
    logic [pazs_pkg::LEVEL_BITS-1:0]    div_divisor;
    logic [DIV_BITS-1:0]                div_quotient;
    pazs_pkg::t_div_stat                div_stat;

    pazs_div #(
        .DIV_BITS (DIV_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_stat     (div_stat)
    );

    // The back end takes queue entries in order. A closing entry divides the
    // sum by the length and refreshes the held remap; every entry then
    // recomputes the speed of the held remap against the current far level
    // and loads one result transaction with its zone.
    pazs_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .i_pop_data     (pop_data),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_quotient (div_quotient),
        .i_div_stat     (div_stat),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire
